// File: src/i3pr_pkg.sv
// Shared types and constants for the ID3 frame payload rewriter.
// No dependencies; imported by every module of the block.
package i3pr_pkg;

    localparam int HEADER_BYTES  = 10;
    localparam int MAX_NEW_BYTES = 32;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;                        // replacement length 0..32
    localparam int IDX_W  = $clog2(MAX_NEW_BYTES);    // replacement byte index
    localparam int TEXT_W = MAX_NEW_BYTES * BYTE_W;   // all replacement bytes

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET_ID = 3'd0;
    localparam logic [2:0] CFG_NEW_LEN   = 3'd1;
    localparam logic [2:0] CFG_WORD0     = 3'd2;
    localparam logic [2:0] CFG_WORD1     = 3'd3;
    localparam logic [2:0] CFG_WORD2     = 3'd4;
    localparam logic [2:0] CFG_WORD3     = 3'd5;

    localparam logic [31:0] TARGET_ID_RST = 32'h5449_5432;

    // one command from the parser to the output side
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              rep;    // byte of the rewritten frame, after its ID
        logic              burst;  // encoding byte followed by replacement bytes
    } t_cmd;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_stat;

endpackage

// File: src/i3pr_front.sv
// Frame parser: tracks tag header and frame fields, issues one command per
// byte that produces output. Depends on i3pr_pkg.
module i3pr_front
    import i3pr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_sof,
    input  logic [31:0]       i_target_id,
    input  logic [LEN_W-1:0]  i_eff_len,
    output logic              o_push,
    output t_cmd              o_cmd
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_SIZE   = 3'd2;
    localparam logic [2:0] PH_FLAGS  = 3'd3;
    localparam logic [2:0] PH_ENC    = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_PASS   = 3'd6;

    logic [2:0]  r_phase, n_phase, w_phase;
    logic [31:0] r_cnt, n_cnt, w_cnt;
    logic [31:0] r_id, n_id, w_id;
    logic [31:0] r_size, n_size, w_size;
    logic        r_match, n_match, w_match;
    logic        r_done, n_done, w_done;
    logic [31:0] w_cnt_inc;
    logic [31:0] w_remaining;
    logic [7:0]  w_new_size;

    // start of file clears the parse state before this byte is handled
    assign w_phase = i_sof ? PH_HEADER : r_phase;
    assign w_cnt   = i_sof ? 32'd0 : r_cnt;
    assign w_id    = i_sof ? 32'd0 : r_id;
    assign w_size  = i_sof ? 32'd0 : r_size;
    assign w_match = i_sof ? 1'b0 : r_match;
    assign w_done  = i_sof ? 1'b0 : r_done;

    assign w_cnt_inc   = w_cnt + 32'd1;
    assign w_remaining = (w_size == 32'd0) ? 32'd0 : w_size - 32'd1;
    assign w_new_size  = 8'(i_eff_len) + 8'd1;

    always_comb begin
        n_phase = w_phase;
        n_cnt   = w_cnt;
        n_id    = w_id;
        n_size  = w_size;
        n_match = w_match;
        n_done  = w_done;
        o_push  = 1'b1;
        o_cmd.data  = i_byte;
        o_cmd.rep   = 1'b0;
        o_cmd.burst = 1'b0;
        unique case (w_phase)
            PH_HEADER: begin
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= 32'(HEADER_BYTES)) begin
                    n_phase = PH_ID;
                    n_cnt   = 32'd0;
                end
            end
            PH_ID: begin
                n_id  = {w_id[23:0], i_byte};
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= 32'd4) begin
                    n_cnt   = 32'd0;
                    n_phase = PH_SIZE;
                    n_match = !w_done && ({w_id[23:0], i_byte} == i_target_id);
                    if (n_match) begin
                        n_done = 1'b1;
                    end
                end
            end
            PH_SIZE: begin
                n_size = {w_size[23:0], i_byte};
                if (w_match) begin
                    // new size is at most 33, so only the last size byte is non-zero
                    o_cmd.data = (w_cnt[1:0] == 2'd3) ? w_new_size : 8'd0;
                    o_cmd.rep  = 1'b1;
                end
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= 32'd4) begin
                    n_cnt   = 32'd0;
                    n_phase = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                o_cmd.rep = w_match;
                n_cnt     = w_cnt_inc;
                if (w_cnt_inc >= 32'd2) begin
                    n_cnt   = 32'd0;
                    n_phase = PH_ENC;
                end
            end
            PH_ENC: begin
                o_cmd.rep   = w_match;
                o_cmd.burst = w_match;
                n_cnt       = w_remaining;
                if (w_remaining == 32'd0) begin
                    n_phase = w_match ? PH_PASS : PH_ID;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                o_push = !w_match;   // data of the rewritten frame is dropped
                n_cnt  = (w_cnt != 32'd0) ? w_cnt - 32'd1 : 32'd0;
                if (n_cnt == 32'd0) begin
                    n_phase = w_match ? PH_PASS : PH_ID;
                end
            end
            default: begin
                // pass-through, also for the unused code
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_cnt   <= 32'd0;
            r_id    <= 32'd0;
            r_size  <= 32'd0;
            r_match <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_id    <= n_id;
            r_size  <= n_size;
            r_match <= n_match;
            r_done  <= n_done;
        end
    end

endmodule

// File: src/i3pr_fifo.sv
// Short command queue between parser and output side.
// Depends on i3pr_pkg.
module i3pr_fifo
    import i3pr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_cmd,
    input  logic       i_pop,
    output t_cmd       o_cmd,
    output t_fifo_stat o_stat
);

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_do_push;
    logic                  w_do_pop;

    assign o_stat.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    assign w_do_push = i_push && !o_stat.full;
    assign w_do_pop  = i_pop && !o_stat.empty;
    assign o_cmd     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/i3pr_back.sv
// Output side: turns queued commands into output words, expanding the
// replacement burst. Depends on i3pr_pkg.
module i3pr_back
    import i3pr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic [LEN_W-1:0]  i_eff_len,
    input  logic [TEXT_W-1:0] i_text,
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_last,
    output logic              o_rep
);

    logic              r_valid, n_valid;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_last, n_last;
    logic              r_rep, n_rep;
    logic [LEN_W-1:0]  r_left, n_left;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              w_adv;

    assign w_adv  = !r_valid || i_ready;
    assign o_busy = (r_left != '0);

    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        n_rep   = r_rep;
        n_left  = r_left;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        if (w_adv) begin
            if (r_left != '0) begin
                n_valid = 1'b1;
                n_byte  = i_text[{r_idx, 3'b000} +: BYTE_W];
                n_rep   = 1'b1;
                n_last  = (r_left == LEN_W'(1));
                n_left  = r_left - 1'b1;
                n_idx   = r_idx + 1'b1;
            end else if (!i_empty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_byte  = i_cmd.data;
                n_rep   = i_cmd.rep;
                n_idx   = '0;
                if (i_cmd.burst) begin
                    n_left = i_eff_len;
                    n_last = (i_eff_len == '0);
                end else begin
                    n_left = '0;
                    n_last = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_left  <= n_left;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_rep  <= n_rep;
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_rep   = r_rep;

endmodule

// File: src/id3_frame_payload_rewriter_top.sv
// ID3v2.3 frame payload rewriter, top level: config registers, parser,
// command queue and output side. Depends on i3pr_pkg and all i3pr_ modules.
// An accepted input word passes the command queue, then the output register.
// One input word per cycle while the queue has room; the encoding byte of the
// rewritten frame is followed by its replacement bytes from the single output register.
// Reset: synchronous active-low; clears parse state, queue and output valid.
module id3_frame_payload_rewriter_top
    import i3pr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input words
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_start_of_file,
    // output words
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last_of_run,
    output logic              o_replaced,
    // configuration writes
    input  logic              i_cfg_wr_en,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_wdata
);

    // Configuration registers
    logic [31:0]      r_target_id;
    logic [LEN_W-1:0] r_new_len;
    logic [63:0]      r_word0, r_word1, r_word2, r_word3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_id <= TARGET_ID_RST;
            r_new_len   <= '0;
            r_word0     <= '0;
            r_word1     <= '0;
            r_word2     <= '0;
            r_word3     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TARGET_ID: r_target_id <= i_cfg_wdata[31:0];
                CFG_NEW_LEN:   r_new_len   <= i_cfg_wdata[LEN_W-1:0];
                CFG_WORD0:     r_word0     <= i_cfg_wdata;
                CFG_WORD1:     r_word1     <= i_cfg_wdata;
                CFG_WORD2:     r_word2     <= i_cfg_wdata;
                CFG_WORD3:     r_word3     <= i_cfg_wdata;
                default: begin
                    // unknown index: write dropped
                end
            endcase
        end
    end

    // Length saturates at the replacement buffer size; used both for the
    // rewritten size field and for the number of burst bytes.
    logic [LEN_W-1:0]  w_eff_len;
    logic [TEXT_W-1:0] w_text;

    assign w_eff_len = (r_new_len > LEN_W'(MAX_NEW_BYTES)) ? LEN_W'(MAX_NEW_BYTES) : r_new_len;
    assign w_text    = {r_word3, r_word2, r_word1, r_word0};

    // Front: parser. Takes a word whenever the queue has room.
    logic       w_in_accept;
    logic       w_push;
    t_cmd       w_push_cmd;
    t_cmd       w_head_cmd;
    t_fifo_stat w_fifo_stat;
    logic       w_pop;
    logic       w_busy;

    assign o_ready     = !w_fifo_stat.full;
    assign w_in_accept = i_valid && o_ready;

    i3pr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_accept),
        .i_byte      (i_in_byte),
        .i_sof       (i_start_of_file),
        .i_target_id (r_target_id),
        .i_eff_len   (w_eff_len),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    // Queue: lets the parser keep taking words during a replacement burst
    i3pr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push && w_in_accept),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_fifo_stat)
    );

    // Back: output register and burst expansion
    i3pr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_head_cmd),
        .i_empty   (w_fifo_stat.empty),
        .o_pop     (w_pop),
        .i_eff_len (w_eff_len),
        .i_text    (w_text),
        .o_busy    (w_busy),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_byte    (o_out_byte),
        .o_last    (o_last_of_run),
        .o_rep     (o_replaced)
    );

    // Checks
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("command queue overfilled");

    a_burst_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> o_valid)
        else $error("burst pending without a word on the output");

    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_of_run) |=> o_valid)
        else $error("run broken before its last word");

    a_plain_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_replaced) |-> o_last_of_run)
        else $error("pass-through word not marked last");

endmodule
